[rtl/decimal_text_to_normalized_int_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef DECIMAL_TEXT_TO_NORMALIZED_INT_TOP_DEFINES_SVH
`define DECIMAL_TEXT_TO_NORMALIZED_INT_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define DTNI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DTNI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dtni_pkg.sv]
`timescale 1ns / 1ps
package dtni_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  localparam int MSG_BYTES = 6;
  localparam int IDX_W     = 3;
  localparam int ADDR_W    = 3;

  // Message handed from the parser to the serializer.
  typedef struct packed {
    logic                        load;
    logic [IDX_W-1:0]            last_idx;
    logic [MSG_BYTES-1:0][7:0]   bytes;
  } msg_load_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] LIM_3B = 32'h00FF_FFFF;
  localparam logic [31:0] LIM_2B = 32'h0000_FFFF;
  localparam logic [31:0] LIM_1B = 32'h0000_00FF;

  localparam logic [7:0] SIGN_BIT  = 8'h80;
  localparam logic [7:0] FRAC_MASK = 8'h0F;

  localparam logic [IDX_W-1:0] LAST_IDX_6 = 3'd5;
  localparam logic [IDX_W-1:0] LAST_IDX_5 = 3'd4;
  localparam logic [IDX_W-1:0] LAST_IDX_4 = 3'd3;
  localparam logic [IDX_W-1:0] LAST_IDX_3 = 3'd2;

  localparam logic REG_UNIT_TYPE = 1'b0;
  localparam logic REG_CODING    = 1'b1;

  localparam logic [7:0] CODING_RESET = 8'h80;

endpackage

[rtl/dtni_parse.sv]
`timescale 1ns / 1ps
module dtni_parse #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  dtni_pkg::in_item_t   in_item,
  input  logic [7:0]           type_byte,
  output dtni_pkg::msg_load_t  msg
);
  import dtni_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [31:0]      accum_r, accum_nxt;
  logic [CNT_W-1:0] digit_count_r, digit_count_nxt;
  logic [CNT_W-1:0] frac_count_r, frac_count_nxt;
  logic             neg_flag_r, neg_flag_nxt;
  logic             point_seen_r, point_seen_nxt;
  logic [3:0]       digit;
  logic [7:0]       frac8;
  logic [7:0]       byte1;

  assign digit = 4'(in_item.char_code - CH_ZERO);

  always_comb begin
    accum_nxt       = accum_r;
    digit_count_nxt = digit_count_r;
    frac_count_nxt  = frac_count_r;
    neg_flag_nxt    = neg_flag_r;
    point_seen_nxt  = point_seen_r;
    if (digit_count_r < CNT_W'(MAX_DIGITS)) begin
      case (in_item.char_code) inside
        CH_PLUS:            neg_flag_nxt = 1'b0;
        CH_MINUS:           neg_flag_nxt = 1'b1;
        CH_COMMA, CH_POINT: point_seen_nxt = 1'b1;
        [CH_ZERO:CH_NINE]: begin
          accum_nxt       = (accum_r << 3) + (accum_r << 1) + 32'(digit);
          digit_count_nxt = digit_count_r + CNT_W'(1);
          if (point_seen_r) begin
            frac_count_nxt = frac_count_r + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Build the message from the state after the final character.
  assign frac8 = 8'(frac_count_nxt);
  assign byte1 = (frac8 & FRAC_MASK) | (neg_flag_nxt ? SIGN_BIT : 8'h00);

  always_comb begin
    msg.load     = take && in_item.is_last;
    msg.bytes    = '0;
    msg.bytes[0] = type_byte;
    msg.bytes[1] = byte1;
    if (accum_nxt > LIM_3B) begin
      msg.last_idx = LAST_IDX_6;
      msg.bytes[2] = accum_nxt[31:24];
      msg.bytes[3] = accum_nxt[23:16];
      msg.bytes[4] = accum_nxt[15:8];
      msg.bytes[5] = accum_nxt[7:0];
    end else if (accum_nxt > LIM_2B) begin
      msg.last_idx = LAST_IDX_5;
      msg.bytes[2] = accum_nxt[23:16];
      msg.bytes[3] = accum_nxt[15:8];
      msg.bytes[4] = accum_nxt[7:0];
    end else if (accum_nxt > LIM_1B) begin
      msg.last_idx = LAST_IDX_4;
      msg.bytes[2] = accum_nxt[15:8];
      msg.bytes[3] = accum_nxt[7:0];
    end else begin
      msg.last_idx = LAST_IDX_3;
      msg.bytes[2] = accum_nxt[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r       <= '0;
      digit_count_r <= '0;
      frac_count_r  <= '0;
      neg_flag_r    <= 1'b0;
      point_seen_r  <= 1'b0;
    end else if (take) begin
      if (in_item.is_last) begin
        accum_r       <= '0;
        digit_count_r <= '0;
        frac_count_r  <= '0;
        neg_flag_r    <= 1'b0;
        point_seen_r  <= 1'b0;
      end else begin
        accum_r       <= accum_nxt;
        digit_count_r <= digit_count_nxt;
        frac_count_r  <= frac_count_nxt;
        neg_flag_r    <= neg_flag_nxt;
        point_seen_r  <= point_seen_nxt;
      end
    end
  end

endmodule

[rtl/dtni_ser.sv]
`timescale 1ns / 1ps
module dtni_ser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtni_pkg::msg_load_t  msg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dtni_pkg::out_item_t  out_data,
  output dtni_pkg::ser_stat_t  stat
);
  import dtni_pkg::*;

  logic                      busy_r;
  logic [IDX_W-1:0]          idx_r;
  logic [IDX_W-1:0]          last_idx_r;
  logic [MSG_BYTES-1:0][7:0] buf_r;
  logic                      at_last;

  assign at_last            = (idx_r == last_idx_r);
  assign out_valid          = busy_r;
  assign out_data.out_byte  = buf_r[idx_r];
  assign out_data.last_byte = at_last;
  assign stat.busy          = busy_r;
  assign stat.done          = busy_r && out_ready && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (msg.load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && out_ready) begin
      // advance, drop busy after the final byte
      if (at_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg.load) begin
      buf_r      <= msg.bytes;
      last_idx_r <= msg.last_idx;
    end
  end

endmodule

[rtl/decimal_text_to_normalized_int_top.sv]
// Decimal text to normalized integer encoder.
// Input channel (in_valid/in_ready/in_data): one character per item, with is_last
// on the final character of a number. Output channel (out_valid/out_ready/out_data):
// the encoded message, 3 to 6 bytes, last_byte set on the final byte.
// APB port: register 0 (byte address 0) unit_type, register 1 (address 4)
// coding_bits; both readable. Write only while the block is idle.
// Throughput: one character per cycle. The first message byte is shown the cycle
// after the last character is taken, then one byte per cycle while out_ready is high.
// A last character is held off while an earlier message still has bytes beyond the
// one being taken; other characters keep flowing during message output.
// The message buffer is the only output storage, so a stalled receiver holds the
// current byte steady and, in turn, stalls the next last character.
// Reset clears the parse state, drops out_valid and sets unit_type 0, coding_bits 0x80.
`timescale 1ns / 1ps
module decimal_text_to_normalized_int_top #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  dtni_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output dtni_pkg::out_item_t                  out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dtni_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import dtni_pkg::*;

  logic [7:0] unit_type_r;
  logic [7:0] coding_bits_r;
  logic       take;
  msg_load_t  msg;
  ser_stat_t  stat;

  assign pready   = 1'b1;
  assign in_ready = !stat.busy || stat.done || !in_data.is_last;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_type_r   <= '0;
      coding_bits_r <= CODING_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_UNIT_TYPE: unit_type_r   <= pwdata[7:0];
        REG_CODING:    coding_bits_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_UNIT_TYPE: prdata = 32'(unit_type_r);
      REG_CODING:    prdata = 32'(coding_bits_r);
      default:       prdata = '0;
    endcase
  end

  dtni_parse #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_item   (in_data),
    .type_byte (unit_type_r | coding_bits_r),
    .msg       (msg)
  );

  dtni_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg       (msg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule

[rtl/dtni_chk.sv]
`timescale 1ns / 1ps
`include "decimal_text_to_normalized_int_top_defines.svh"
module dtni_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input dtni_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input dtni_pkg::out_item_t out_data,
  input logic                pready
);
  import dtni_pkg::*;

  `DTNI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_data), "stalled output item changed")

  `DTNI_ASSERT_NEXT(a_msg_start, clk, rst_n, in_valid && in_ready && in_data.is_last,
    out_valid, "no message after last character")

  `DTNI_ASSERT_NEXT(a_msg_gapless, clk, rst_n,
    out_valid && out_ready && !out_data.last_byte,
    out_valid, "gap inside a message")

  `DTNI_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_ready && !pready == 1'b0,
    out_valid, "input stalled with no message in flight")

endmodule

bind decimal_text_to_normalized_int_top dtni_chk u_chk (.*);
